@@ hw/rtl/bal_pkg.sv @@
`default_nettype none

package bal_pkg;

   // Store geometry and field widths.
   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = 5;
   localparam int DATA_W      = 32;
   localparam int CMD_W       = 3;
   localparam int POS_W       = 5;
   localparam int ST_W        = 2;

   // Capacity register value after reset.
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

   // Command codes on the request channel; the remaining codes do nothing.
   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND  = 3'd0,
      CMD_INSERT  = 3'd1,
      CMD_DELETE  = 3'd2,
      CMD_SORT    = 3'd3,
      CMD_REVERSE = 3'd4,
      CMD_DUMP    = 3'd5
   } cmd_type;

   // Status codes on the response channel.
   typedef enum logic [ST_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPOS = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   // Work the back end carries out for one classified command.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_DELETE,
      OP_SORT,
      OP_REVERSE,
      OP_DUMP
   } op_type;

   // One classified command, passed from the front end to the back end.
   typedef struct packed {
      op_type                    op;
      status_type                status;
      logic [IDX_W-1:0]          idx;
      logic signed [DATA_W-1:0]  value;
      logic [CNT_W-1:0]          count;
   } job_type;

   // One response beat.
   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  data;
      logic [CNT_W-1:0]          count;
      logic                      last;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/bal_front.sv @@
`default_nettype none

module bal_front import bal_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [CMD_W-1:0]          req_command,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic                      csr_write_enable,
   input  logic [CNT_W-1:0]          csr_capacity_in_use,
   input  logic                      job_full,
   output logic                      job_push,
   output job_type                   job_data
);

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] eff_cap;
   logic             list_full;
   logic             accept;
   logic [CNT_W:0]   pos_wide;
   logic [CNT_W:0]   count_wide;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   // A beat is taken whenever the job queue has room.
   assign req_full = job_full;
   assign accept   = req_push && !job_full;
   assign job_push = accept;

   // The capacity saturates at the size of the store.
   assign eff_cap    = (cap_ff > MAX_CNT) ? MAX_CNT : cap_ff;
   assign list_full  = count_ff >= eff_cap;
   assign pos_wide   = {1'b0, req_position};
   assign count_wide = {1'b0, count_ff};

   // Classify the command against the list length as it will be after all earlier jobs.
   always_comb begin
      job_data.op     = OP_NONE;
      job_data.status = ST_OK;
      job_data.idx    = IDX_W'(req_position - POS_W'(1));
      job_data.value  = req_value;
      count_in        = count_ff;
      unique case (req_command)
         CMD_APPEND: begin
            if (list_full) begin
               job_data.status = ST_FULL;
            end else begin
               job_data.op  = OP_INSERT;
               job_data.idx = IDX_W'(count_ff);
               count_in     = count_ff + CNT_W'(1);
            end
         end
         CMD_INSERT: begin
            if (list_full) begin
               job_data.status = ST_FULL;
            end else if (req_position == '0 || pos_wide > count_wide + (CNT_W+1)'(1)) begin
               job_data.status = ST_BADPOS;
            end else begin
               job_data.op = OP_INSERT;
               count_in    = count_ff + CNT_W'(1);
            end
         end
         CMD_DELETE: begin
            if (count_ff == '0) begin
               job_data.status = ST_EMPTY;
            end else if (req_position == '0 || pos_wide > count_wide) begin
               job_data.status = ST_BADPOS;
            end else begin
               job_data.op = OP_DELETE;
               count_in    = count_ff - CNT_W'(1);
            end
         end
         CMD_SORT: begin
            if (count_ff > CNT_W'(1)) begin
               job_data.op = OP_SORT;
            end
         end
         CMD_REVERSE: begin
            if (count_ff > CNT_W'(1)) begin
               job_data.op = OP_REVERSE;
            end
         end
         CMD_DUMP: begin
            if (count_ff == '0) begin
               job_data.status = ST_EMPTY;
            end else begin
               job_data.op = OP_DUMP;
            end
         end
         default: begin
            job_data.op = OP_NONE;
         end
      endcase
      job_data.count = count_in;
   end

   // Capacity register and the running list length.
   always_comb begin
      cap_in = csr_write_enable ? csr_capacity_in_use : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         count_ff <= '0;
      end else begin
         cap_ff <= cap_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/bal_job_queue.sv @@
`default_nettype none

module bal_job_queue import bal_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   job_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push;
   logic       do_pop;

   // Two-entry ring of jobs between front and back end.
   assign full    = fill_ff == 2'd2;
   assign empty   = fill_ff == 2'd0;
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/bal_rsp_queue.sv @@
`default_nettype none

module bal_rsp_queue import bal_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   input  logic    pop,
   output rsp_type head,
   output logic    empty
);

   rsp_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push;
   logic       do_pop;

   // Two-entry ring of response beats; a stalled receiver holds the back end once both entries are full.
   assign full    = fill_ff == 2'd2;
   assign empty   = fill_ff == 2'd0;
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/bal_back.sv @@
`default_nettype none

module bal_back import bal_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job_data,
   output logic    job_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_FINISH,
      S_DUMP
   } state_type;

   state_type                 state_ff, state_in;
   op_type                    op_ff, op_in;
   logic [IDX_W-1:0]          round_ff, round_in;
   logic [IDX_W-1:0]          ptr_ff, ptr_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [DATA_W-1:0]  store_ff [MAX_ENTRIES];
   logic signed [DATA_W-1:0]  store_in [MAX_ENTRIES];
   logic [IDX_W-1:0]          tag_ff [MAX_ENTRIES];
   logic [IDX_W-1:0]          tag_in [MAX_ENTRIES];
   logic [IDX_W-1:0]          rd_idx;
   logic signed [DATA_W-1:0]  rd_word;
   logic                      dump_last;
   logic                      swap;

   // Single read port: the dump walk or the delete position.
   assign rd_idx    = (state_ff == S_DUMP) ? ptr_ff : job_data.idx;
   assign rd_word   = store_ff[rd_idx];
   assign dump_last = (CNT_W'(ptr_ff) + CNT_W'(1)) == cnt_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      round_in = round_ff;
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      store_in = store_ff;
      tag_in   = tag_ff;
      swap     = 1'b0;
      job_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_data.status = ST_OK;
      rsp_data.data   = '0;
      rsp_data.count  = cnt_ff;
      rsp_data.last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               unique case (job_data.op)
                  // Rejected or no-effect commands give a single status beat.
                  OP_NONE: begin
                     if (!rsp_full) begin
                        job_pop         = 1'b1;
                        rsp_push        = 1'b1;
                        rsp_data.status = job_data.status;
                        rsp_data.count  = job_data.count;
                     end
                  end
                  // Every entry at or above the slot moves up by one in the same cycle.
                  OP_INSERT: begin
                     if (!rsp_full) begin
                        for (int i = 1; i < MAX_ENTRIES; i++) begin
                           if (IDX_W'(i) > job_data.idx) begin
                              store_in[i] = store_ff[i-1];
                           end
                        end
                        store_in[job_data.idx] = job_data.value;
                        job_pop        = 1'b1;
                        rsp_push       = 1'b1;
                        rsp_data.count = job_data.count;
                     end
                  end
                  // The removed word goes out while everything above it moves down.
                  OP_DELETE: begin
                     if (!rsp_full) begin
                        for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                           if (IDX_W'(i) >= job_data.idx) begin
                              store_in[i] = store_ff[i+1];
                           end
                        end
                        job_pop        = 1'b1;
                        rsp_push       = 1'b1;
                        rsp_data.data  = rd_word;
                        rsp_data.count = job_data.count;
                     end
                  end
                  // Sort and reverse share the odd-even transposition sweep.
                  OP_SORT, OP_REVERSE: begin
                     job_pop  = 1'b1;
                     op_in    = job_data.op;
                     cnt_in   = job_data.count;
                     round_in = '0;
                     state_in = S_SWEEP;
                     for (int i = 0; i < MAX_ENTRIES; i++) begin
                        tag_in[i] = IDX_W'(i);
                     end
                  end
                  OP_DUMP: begin
                     job_pop  = 1'b1;
                     cnt_in   = job_data.count;
                     ptr_in   = '0;
                     state_in = S_DUMP;
                  end
                  default: begin
                     job_pop = 1'b1;
                  end
               endcase
            end
         end

         // One round of neighbor compare-exchange inside the valid part of the list.
         // Reverse orders by descending original position instead of by value.
         S_SWEEP: begin
            for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
               if ((i % 2) == int'(round_ff[0]) && CNT_W'(i + 1) < cnt_ff) begin
                  if (op_ff == OP_SORT) begin
                     swap = store_ff[i] > store_ff[i+1];
                  end else begin
                     swap = tag_ff[i] < tag_ff[i+1];
                  end
                  if (swap) begin
                     store_in[i]   = store_ff[i+1];
                     store_in[i+1] = store_ff[i];
                     tag_in[i]     = tag_ff[i+1];
                     tag_in[i+1]   = tag_ff[i];
                  end
               end
            end
            round_in = round_ff + IDX_W'(1);
            if (round_ff == IDX_W'(MAX_ENTRIES - 1)) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end

         // One element per beat, in list order.
         S_DUMP: begin
            if (!rsp_full) begin
               rsp_push      = 1'b1;
               rsp_data.data = rd_word;
               rsp_data.last = dump_last;
               ptr_in        = ptr_ff + IDX_W'(1);
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry store and sweep tags.
   always_ff @(posedge clock) begin
      store_ff <= store_in;
      tag_ff   <= tag_in;
   end

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_NONE;
         round_ff <= '0;
         ptr_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         round_ff <= round_in;
         ptr_ff   <= ptr_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/bounded_array_list.sv @@
// Bounded array list: an ordered list of signed 32-bit words, up to 16 entries.
// Request channel (req_): a queue-style input; a command beat is taken when
// req_push is high and req_full is low. Commands: append, insert, delete, sort,
// reverse, dump. Positions are 1-based.
// Response channel (rsp_): the oldest beat is shown while rsp_empty is low and
// leaves when rsp_pop is high. Each command gives one beat, except a dump of a
// non-empty list, which gives one beat per element; rsp_last marks the final one.
// The capacity register is written through csr_write_enable; the user must write
// it only while the block idles, as the block itself does not enforce this.
// A taken command is registered in the job queue; the back end takes it from the
// queue head and registers its beats in the response queue, which drives the rsp_
// ports. Append, insert, delete and rejected commands are carried out without the
// back end leaving its idle state. Sort and reverse run a 16-round compare-exchange
// sweep and then give their beat; a dump gives one element per cycle while the
// response queue has room. The back end works on one command at a time and sets
// the sustained rate; a two-entry job queue lets new commands enter while it is
// busy. A stalled receiver fills the two-entry response queue, which then holds
// the back end and, once the job queue fills, raises req_full.
// Reset empties the list and both queues and sets the capacity to 16.
`default_nettype none

module bounded_array_list import bal_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [CMD_W-1:0]          req_command,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_value,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [ST_W-1:0]           rsp_status,
   output logic signed [DATA_W-1:0]  rsp_data,
   output logic [CNT_W-1:0]          rsp_count,
   output logic                      rsp_last,
   input  logic                      csr_write_enable,
   input  logic [CNT_W-1:0]          csr_capacity_in_use
);

   logic    job_full;
   logic    job_push;
   job_type job_in_data;
   logic    job_empty;
   logic    job_pop;
   job_type job_head;
   logic    beat_full;
   logic    beat_push;
   rsp_type beat_data;
   rsp_type beat_head;

   // Front end: takes commands and classifies them.
   bal_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_command         (req_command),
      .req_position        (req_position),
      .req_value           (req_value),
      .csr_write_enable    (csr_write_enable),
      .csr_capacity_in_use (csr_capacity_in_use),
      .job_full            (job_full),
      .job_push            (job_push),
      .job_data            (job_in_data)
   );

   bal_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty)
   );

   // Back end: owns the store and carries out the jobs.
   bal_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (job_head),
      .job_pop   (job_pop),
      .rsp_full  (beat_full),
      .rsp_push  (beat_push),
      .rsp_data  (beat_data)
   );

   bal_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (beat_push),
      .push_data (beat_data),
      .full      (beat_full),
      .pop       (rsp_pop),
      .head      (beat_head),
      .empty     (rsp_empty)
   );

   // Response beat fields.
   assign rsp_status = beat_head.status;
   assign rsp_data   = beat_head.data;
   assign rsp_count  = beat_head.count;
   assign rsp_last   = beat_head.last;

endmodule

`default_nettype wire

@@ sim/bounded_array_list_test.sv @@
`default_nettype none

module bounded_array_list_test import bal_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // Command codes that the block treats as no-ops.
   localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PHASE_ITEMS    = 70;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [CMD_W-1:0]          command;
      logic [POS_W-1:0]          position;
      logic signed [DATA_W-1:0]  value;
   } list_cmd_type;

   // Block ports; every input is driven to a known value from time zero.
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [CMD_W-1:0]          req_command = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [DATA_W-1:0]  req_value = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [ST_W-1:0]           rsp_status;
   logic signed [DATA_W-1:0]  rsp_data;
   logic [CNT_W-1:0]          rsp_count;
   logic                      rsp_last;
   logic                      csr_write_enable = 1'b0;
   logic [CNT_W-1:0]          csr_capacity_in_use = '0;

   // Shadow list, kept in step with every accepted command.
   logic signed [DATA_W-1:0]  list_words [MAX_ENTRIES];
   int                        list_len = 0;
   logic [CNT_W-1:0]          cap_reg = CAP_RESET;

   list_cmd_type              pending_cmds [$];
   rsp_type                   expected_beats [$];

   // Handshake bookkeeping shared between the clocked processes.
   int unsigned req_beats = 0;
   int unsigned sent_beats = 0;
   int unsigned rsp_beats = 0;
   int unsigned cap_writes = 0;
   int unsigned full_stalls = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_asks = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned send_gap = 0;
   int unsigned pop_gap = 0;
   bit          idle_on = 1'b1;

   bounded_array_list u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_command         (req_command),
      .req_position        (req_position),
      .req_value           (req_value),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_status          (rsp_status),
      .rsp_data            (rsp_data),
      .rsp_count           (rsp_count),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_capacity_in_use (csr_capacity_in_use)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Records one expected response beat; count is the list length after the command.
   function automatic void add_beat(input status_type st, input logic signed [DATA_W-1:0] d,
                                    input logic lst);
      rsp_type b;
      b.status = st;
      b.data   = d;
      b.count  = CNT_W'(list_len);
      b.last   = lst;
      expected_beats.push_back(b);
   endfunction

   // Applies one command to the shadow list and queues the beats it produces.
   function automatic void predict_beats(input logic [CMD_W-1:0] cmd,
                                         input logic [POS_W-1:0] pos,
                                         input logic signed [DATA_W-1:0] val);
      int                        cap_eff;
      int                        p;
      int                        i;
      int                        j;
      bit                        at_limit;
      status_type                st;
      logic signed [DATA_W-1:0]  removed;
      logic signed [DATA_W-1:0]  swap;
      cap_eff  = (int'(cap_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg);
      at_limit = list_len >= cap_eff;
      p        = int'(pos);
      st       = ST_OK;
      removed  = '0;
      case (cmd)
         CMD_APPEND: begin
            if (at_limit) begin
               st = ST_FULL;
            end else begin
               list_words[list_len] = val;
               list_len++;
            end
         end
         CMD_INSERT: begin
            // The full check wins over a bad position.
            if (at_limit) begin
               st = ST_FULL;
            end else if (p < 1 || p > list_len + 1) begin
               st = ST_BADPOS;
            end else begin
               for (i = list_len; i >= p; i--) list_words[i] = list_words[i-1];
               list_words[p-1] = val;
               list_len++;
            end
         end
         CMD_DELETE: begin
            if (list_len == 0) begin
               st = ST_EMPTY;
            end else if (p < 1 || p > list_len) begin
               st = ST_BADPOS;
            end else begin
               removed = list_words[p-1];
               for (i = p; i < list_len; i++) list_words[i-1] = list_words[i];
               list_len--;
            end
         end
         CMD_SORT: begin
            for (i = 0; i + 1 < list_len; i++) begin
               for (j = i + 1; j < list_len; j++) begin
                  if (list_words[i] > list_words[j]) begin
                     swap          = list_words[i];
                     list_words[i] = list_words[j];
                     list_words[j] = swap;
                  end
               end
            end
         end
         CMD_REVERSE: begin
            i = 0;
            j = list_len - 1;
            while (i < j) begin
               swap          = list_words[i];
               list_words[i] = list_words[j];
               list_words[j] = swap;
               i++;
               j--;
            end
         end
         CMD_DUMP: begin
            // A non-empty dump gives one beat per element and nothing else.
            if (list_len == 0) begin
               st = ST_EMPTY;
            end else begin
               for (i = 0; i < list_len; i++) add_beat(ST_OK, list_words[i], i == list_len - 1);
               return;
            end
         end
         default: ;
      endcase
      add_beat(st, removed, 1'b1);
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // Samples both channels and the register port at the rising edge.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      bit      progress;
      if (!reset) begin
         progress = 1'b0;
         if (csr_write_enable) begin
            cap_reg = csr_capacity_in_use;
            cap_writes++;
         end
         if (req_push && req_full) full_stalls++;
         if (req_push && !req_full) begin
            predict_beats(req_command, req_position, req_value);
            req_beats++;
            progress = 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            progress   = 1'b1;
            got.status = status_type'(rsp_status);
            got.data   = rsp_data;
            got.count  = rsp_count;
            got.last   = rsp_last;
            if (expected_beats.size() == 0) begin
               note_failure($sformatf("beat %0d arrived with nothing expected: status %0d data %0d",
                                      rsp_beats, got.status, got.data));
            end else begin
               want = expected_beats.pop_front();
               if (got.status !== want.status || got.data !== want.data ||
                   got.count !== want.count || got.last !== want.last) begin
                  note_failure($sformatf({"beat %0d: expected status %0d data %0d count %0d ",
                                          "last %0d, got status %0d data %0d count %0d last %0d"},
                                         rsp_beats, want.status, want.data, want.count,
                                         want.last, got.status, got.data, got.count, got.last));
               end
            end
            rsp_beats++;
         end
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
      end
   end

   // Command driver: holds a beat until it is taken, with random gaps between beats.
   always @(negedge clock) begin
      list_cmd_type next_cmd;
      bit           offer_open;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         offer_open = req_push && (req_beats == sent_beats);
         if (req_push && !offer_open) sent_beats = req_beats;
         if (!offer_open) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
               req_push <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 12);
               req_push <= 1'b0;
            end else begin
               next_cmd = pending_cmds.pop_front();
               req_command  <= next_cmd.command;
               req_position <= next_cmd.position;
               req_value    <= next_cmd.value;
               req_push     <= 1'b1;
            end
         end
      end
   end

   // Response receiver: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_served != hold_asks) begin
         hold_served = hold_asks;
         hold_left   = LONG_HOLD - 1;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         rsp_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         pop_gap = $urandom_range(0, 12);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Ends a hung run.
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Watchdog: no beat accepted for %0d cycles", quiet_cycles);
      $display("bounded_array_list verification failed");
      $finish;
   end

   task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val);
      list_cmd_type c;
      c.command  = cmd;
      c.position = pos;
      c.value    = val;
      pending_cmds.push_back(c);
   endtask

   // Waits until every command has gone in and every expected beat has come out.
   task automatic drain();
      while (pending_cmds.size() != 0 || req_push || expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] cap);
      drain();
      @(negedge clock);
      csr_capacity_in_use <= cap;
      csr_write_enable    <= 1'b1;
      @(negedge clock);
      csr_write_enable    <= 1'b0;
   endtask

   // Mix of small values for duplicates in sorts, the extremes, and full-range noise.
   function automatic logic signed [DATA_W-1:0] random_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20) return DATA_W'(int'($urandom_range(0, 6)) - 3);
      if (r < 30) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   // Mostly legal positions, some zero and some beyond the store.
   function automatic logic [POS_W-1:0] random_position();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 88) return POS_W'($urandom_range(1, 16));
      if (r < 94) return '0;
      return POS_W'($urandom_range(17, 31));
   endfunction

   task automatic queue_random(input int unsigned append_weight);
      logic [CMD_W-1:0] cmd;
      int unsigned      r;
      if ($urandom_range(0, 99) < append_weight) begin
         cmd = CMD_APPEND;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 25)      cmd = CMD_INSERT;
         else if (r < 55) cmd = CMD_DELETE;
         else if (r < 67) cmd = CMD_SORT;
         else if (r < 77) cmd = CMD_REVERSE;
         else if (r < 94) cmd = CMD_DUMP;
         else             cmd = r[0] ? CMD_UNDEF_LO : CMD_UNDEF_HI;
      end
      queue_cmd(cmd, random_position(), random_value());
   endtask

   initial begin
      logic [CNT_W-1:0] phase_caps [7];
      int unsigned      phase_appends [7];
      int               ph;
      phase_caps    = '{5'd31, 5'd3, 5'd16, 5'd0, 5'd1, 5'd8, 5'd16};
      phase_appends = '{45, 40, 50, 40, 40, 35, 35};
      phase_caps[5] = CNT_W'($urandom_range(2, 15));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty-list behavior and the no-op codes.
      queue_cmd(CMD_DUMP, 5'd1, '0);
      queue_cmd(CMD_DELETE, 5'd1, '0);
      queue_cmd(CMD_SORT, 5'd0, '0);
      queue_cmd(CMD_REVERSE, 5'd0, '0);
      queue_cmd(CMD_UNDEF_LO, 5'd31, -32'sd1);
      queue_cmd(CMD_UNDEF_HI, 5'd0, 32'sh7fff_ffff);
      // Insert bounds, then build a small list with the value extremes.
      queue_cmd(CMD_INSERT, 5'd0, 32'sd9);
      queue_cmd(CMD_INSERT, 5'd2, 32'sd9);
      queue_cmd(CMD_INSERT, 5'd1, 32'sh8000_0000);
      queue_cmd(CMD_APPEND, 5'd0, 32'sh7fff_ffff);
      queue_cmd(CMD_APPEND, 5'd31, 32'sd0);
      queue_cmd(CMD_APPEND, 5'd16, -32'sd1);
      queue_cmd(CMD_INSERT, 5'd5, 32'sd5);
      queue_cmd(CMD_INSERT, 5'd1, 32'sd123);
      // Delete bounds, last and first positions.
      queue_cmd(CMD_DELETE, 5'd0, '0);
      queue_cmd(CMD_DELETE, 5'd31, '0);
      queue_cmd(CMD_DELETE, 5'd6, '0);
      queue_cmd(CMD_DELETE, 5'd1, '0);
      queue_cmd(CMD_REVERSE, 5'd0, '0);
      queue_cmd(CMD_DUMP, 5'd0, '0);
      queue_cmd(CMD_SORT, 5'd0, '0);
      queue_cmd(CMD_DUMP, 5'd0, '0);

      // Capacity lowered below the count: full wins over a bad insert position.
      write_capacity(5'd2);
      queue_cmd(CMD_APPEND, 5'd1, 32'sd77);
      queue_cmd(CMD_INSERT, 5'd9, 32'sd77);
      queue_cmd(CMD_DELETE, 5'd1, '0);
      queue_cmd(CMD_DELETE, 5'd1, '0);
      queue_cmd(CMD_APPEND, 5'd1, 32'sd77);

      // Random phases, each under its own capacity; the register is only written
      // once the previous phase has fully drained.
      for (ph = 0; ph < 7; ph++) begin
         write_capacity(phase_caps[ph]);
         if (ph == 6) idle_on = 1'b0;
         // Stall the receiver long enough for the block to push back on input.
         if (ph == 2) hold_asks++;
         repeat (PHASE_ITEMS) queue_random(phase_appends[ph]);
      end
      drain();

      if (expected_beats.size() != 0)
         note_failure($sformatf("%0d expected beats never arrived", expected_beats.size()));
      $display("Summary: %0d commands driven, %0d result beats checked, %0d capacity writes",
               req_beats, rsp_beats, cap_writes);
      $display("Summary: %0d cycles of input back-pressure seen, %0d failures",
               full_stalls, fail_count);
      if (fail_count == 0) begin
         $display("bounded_array_list verification clean");
      end else begin
         $display("bounded_array_list verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/bal_pkg.sv
hw/rtl/bal_front.sv
hw/rtl/bal_job_queue.sv
hw/rtl/bal_rsp_queue.sv
hw/rtl/bal_back.sv
hw/rtl/bounded_array_list.sv
sim/bounded_array_list_test.sv
